// ----- design/quantum_gate_descriptor_encoder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the quantum gate descriptor encoder
// Concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef QUANTUM_GATE_DESCRIPTOR_ENCODER_ASSERT_SVH
`define QUANTUM_GATE_DESCRIPTOR_ENCODER_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define QGDE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define QGDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/qgde_pkg.sv -----
// ---------------------------------------------------------------------------
// qgde_pkg
// Types, codes and constants of the quantum gate descriptor encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qgde_pkg;

   localparam int unsigned CORDIC_ITERATIONS_DEFAULT = 30;
   localparam int unsigned FRACTION_BITS             = 30;
   localparam int unsigned FRACTION_SHIFT            = 30 - FRACTION_BITS;

   // field widths
   localparam int unsigned FUNC_W     = 3;
   localparam int unsigned QUBIT_W    = 5;
   localparam int unsigned ANGLE_W    = 32;
   localparam int unsigned OPERAND_W  = 27;
   localparam int unsigned ROT_W      = 32;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned STRIDE_W   = 17;
   localparam int unsigned TARGET_LSB = 17;
   localparam int unsigned CONTROL_LSB = 22;

   // datapath widths: range reduction and CORDIC vector
   localparam int unsigned RED_W = 36;
   localparam int unsigned CW    = 34;

   localparam logic [QUBIT_W-1:0] MAX_QUBITS        = 5'd17;
   localparam logic [QUBIT_W-1:0] QUBIT_COUNT_RESET = 5'd3;

   // gate request codes
   localparam logic [FUNC_W-1:0] FUNC_H    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_S    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CNOT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RX   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RY   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_RZ   = 3'd5;

   // gate memory codes
   localparam logic [CODE_W-1:0] GATE_CODE_NONE = 3'd0;
   localparam logic [CODE_W-1:0] GATE_CODE_H    = 3'd1;
   localparam logic [CODE_W-1:0] GATE_CODE_S    = 3'd2;
   localparam logic [CODE_W-1:0] GATE_CODE_CNOT = 3'd3;
   localparam logic [CODE_W-1:0] GATE_CODE_RX   = 3'd4;
   localparam logic [CODE_W-1:0] GATE_CODE_RY   = 3'd5;
   localparam logic [CODE_W-1:0] GATE_CODE_RZ   = 3'd6;

   // Q2.30 angle constants
   localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [RED_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0]    GAIN_INV_Q30 = 34'sd652032874;
   localparam logic signed [CW-1:0]    ONE_Q30      = 34'sd1073741824;
   localparam logic signed [CW-1:0]    OUT_LIMIT    = CW'(ONE_Q30 >>> FRACTION_SHIFT);

   // arctangent of 2^-i, Q2.30
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // side information that travels with each transaction
   typedef struct packed {
      logic [OPERAND_W-1:0] operand_word;
      logic [CODE_W-1:0]    gate_code;
      logic                 rotation;
      logic                 flip;
   } meta_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } vector_type;

endpackage

`default_nettype wire

// ----- design/qgde_channels.sv -----
// ---------------------------------------------------------------------------
// qgde channels
// Valid/ready channel interfaces for gate requests, descriptors and the
// qubit count register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qgde_req_if;
   logic                                valid;
   logic                                ready;
   logic [qgde_pkg::FUNC_W-1:0]         func;
   logic [qgde_pkg::QUBIT_W-1:0]        target;
   logic [qgde_pkg::QUBIT_W-1:0]        control;
   logic signed [qgde_pkg::ANGLE_W-1:0] angle;

   modport source (output valid, output func, output target, output control,
                   output angle, input ready);
   modport sink   (input valid, input func, input target, input control,
                   input angle, output ready);
endinterface

interface qgde_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [qgde_pkg::OPERAND_W-1:0]      operand_word;
   logic signed [qgde_pkg::ROT_W-1:0]   cos_word;
   logic signed [qgde_pkg::ROT_W-1:0]   sin_word;
   logic [qgde_pkg::CODE_W-1:0]         gate_code;

   modport source (output valid, output operand_word, output cos_word,
                   output sin_word, output gate_code, input ready);
   modport sink   (input valid, input operand_word, input cos_word,
                   input sin_word, input gate_code, output ready);
endinterface

interface qgde_csr_if;
   logic                         valid;
   logic                         ready;
   logic [qgde_pkg::QUBIT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/qgde_angle_reduce.sv -----
// ---------------------------------------------------------------------------
// qgde_angle_reduce
// Three-stage reduction of the half angle into [-pi/2, pi/2] with a fold flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgde_angle_reduce (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  qgde_pkg::meta_type                  in_meta,
   input  logic signed [qgde_pkg::ANGLE_W-1:0] in_angle,
   output logic                                out_valid,
   output qgde_pkg::meta_type                  out_meta,
   output qgde_pkg::vector_type                out_vec
);
   import qgde_pkg::*;

   logic                    rem_valid_ff, norm_valid_ff, fold_valid_ff;
   meta_type                rem_meta_ff, norm_meta_ff, fold_meta_ff, fold_meta_in;
   logic signed [RED_W-1:0] quad;
   logic signed [RED_W-1:0] rem_ff, rem_in;
   logic signed [RED_W-1:0] norm_ff, norm_in;
   logic signed [RED_W-1:0] fold_in;
   vector_type              fold_vec_ff;

   // half angle in Q2.30 is the Q4.27 angle times four
   assign quad = $signed({{(RED_W-ANGLE_W-2){in_angle[ANGLE_W-1]}}, in_angle, 2'b00});

   // truncating remainder by 2*pi
   always_comb begin
      if (quad >= TWO_PI_Q30) begin
         rem_in = quad - TWO_PI_Q30;
      end else if (quad <= -TWO_PI_Q30) begin
         rem_in = quad + TWO_PI_Q30;
      end else begin
         rem_in = quad;
      end
   end

   // into [-pi, pi)
   always_comb begin
      if (rem_ff >= PI_Q30) begin
         norm_in = rem_ff - TWO_PI_Q30;
      end else if (rem_ff < -PI_Q30) begin
         norm_in = rem_ff + TWO_PI_Q30;
      end else begin
         norm_in = rem_ff;
      end
   end

   // fold by pi into [-pi/2, pi/2]
   always_comb begin
      fold_meta_in = norm_meta_ff;
      fold_meta_in.flip = 1'b1;
      if (norm_ff > HALF_PI_Q30) begin
         fold_in = norm_ff - PI_Q30;
      end else if (norm_ff < -HALF_PI_Q30) begin
         fold_in = norm_ff + PI_Q30;
      end else begin
         fold_in = norm_ff;
         fold_meta_in.flip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_valid_ff  <= 1'b0;
         norm_valid_ff <= 1'b0;
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         rem_valid_ff  <= in_valid;
         norm_valid_ff <= rem_valid_ff;
         fold_valid_ff <= norm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff        <= rem_in;
         rem_meta_ff   <= in_meta;
         norm_ff       <= norm_in;
         norm_meta_ff  <= rem_meta_ff;
         fold_meta_ff  <= fold_meta_in;
         fold_vec_ff.x <= GAIN_INV_Q30;
         fold_vec_ff.y <= '0;
         fold_vec_ff.z <= CW'(fold_in);
      end
   end

   assign out_valid = fold_valid_ff;
   assign out_meta  = fold_meta_ff;
   assign out_vec   = fold_vec_ff;

endmodule

`default_nettype wire

// ----- design/qgde_cordic_stage.sv -----
// ---------------------------------------------------------------------------
// qgde_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgde_cordic_stage #(
   parameter int unsigned STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  qgde_pkg::meta_type   in_meta,
   input  qgde_pkg::vector_type in_vec,
   output logic                 out_valid,
   output qgde_pkg::meta_type   out_meta,
   output qgde_pkg::vector_type out_vec
);
   import qgde_pkg::*;

   logic                 valid_ff;
   meta_type             meta_ff;
   vector_type           vec_ff, vec_in;
   logic signed [CW-1:0] dx, dy, step;

   assign dx   = in_vec.y >>> STAGE;
   assign dy   = in_vec.x >>> STAGE;
   assign step = $signed({{(CW-32){1'b0}}, ATAN_Q30[STAGE]});

   always_comb begin
      if (in_vec.z >= 0) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - step;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff  <= vec_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

// ----- design/qgde_finish.sv -----
// ---------------------------------------------------------------------------
// qgde_finish
// Sign fold, saturation to Q1.FRACTION_BITS and the descriptor output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgde_finish (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  qgde_pkg::meta_type                in_meta,
   input  qgde_pkg::vector_type              in_vec,
   output logic                              out_valid,
   output logic [qgde_pkg::OPERAND_W-1:0]    out_operand_word,
   output logic signed [qgde_pkg::ROT_W-1:0] out_cos_word,
   output logic signed [qgde_pkg::ROT_W-1:0] out_sin_word,
   output logic [qgde_pkg::CODE_W-1:0]       out_gate_code
);
   import qgde_pkg::*;

   function automatic logic signed [ROT_W-1:0] saturate(input logic signed [CW-1:0] v,
                                                        input logic flip,
                                                        input logic rotation);
      logic signed [CW-1:0] s, c, r;
      s = flip ? -v : v;
      if (s > ONE_Q30) begin
         c = ONE_Q30;
      end else if (s < -ONE_Q30) begin
         c = -ONE_Q30;
      end else begin
         c = s;
      end
      c = c >>> FRACTION_SHIFT;
      if (c > OUT_LIMIT) begin
         r = OUT_LIMIT;
      end else if (c < -OUT_LIMIT) begin
         r = -OUT_LIMIT;
      end else begin
         r = c;
      end
      return rotation ? ROT_W'(r) : '0;
   endfunction

   logic                    valid_ff;
   logic [OPERAND_W-1:0]    operand_ff;
   logic signed [ROT_W-1:0] cos_ff, sin_ff;
   logic [CODE_W-1:0]       code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         operand_ff <= in_meta.operand_word;
         code_ff    <= in_meta.gate_code;
         cos_ff     <= saturate(in_vec.x, in_meta.flip, in_meta.rotation);
         sin_ff     <= saturate(in_vec.y, in_meta.flip, in_meta.rotation);
      end
   end

   assign out_valid        = valid_ff;
   assign out_operand_word = operand_ff;
   assign out_cos_word     = cos_ff;
   assign out_sin_word     = sin_ff;
   assign out_gate_code    = code_ff;

endmodule

`default_nettype wire

// ----- design/quantum_gate_descriptor_encoder.sv -----
// ---------------------------------------------------------------------------
// quantum_gate_descriptor_encoder
// Turns gate requests into gate memory descriptors: operand word, cos and
// sin of the half rotation angle, and the gate code.
// ---------------------------------------------------------------------------
// One transaction per cycle in, one descriptor per cycle out, while no descriptor
// sits unread. Every request passes from acceptance to its descriptor being
// offered through registered angle reduction (remainder by 2*pi, wrap into
// [-pi, pi), fold by pi), a registered stage for each CORDIC micro-rotation,
// and saturation into the output register. The whole pipeline holds when a
// descriptor sits unread, so req_chan.ready follows rsp_chan.ready then.
// Requests with an unknown func code (6 or 7) are accepted and produce no
// descriptor. The qubit count register may be written only while the
// pipeline is empty; csr_chan is always ready.
`timescale 1ns / 1ps
`default_nettype none

module quantum_gate_descriptor_encoder #(
   parameter int unsigned CORDIC_ITERATIONS = qgde_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   qgde_req_if.sink   req_chan,
   qgde_rsp_if.source rsp_chan,
   qgde_csr_if.sink   csr_chan
);
   import qgde_pkg::*;

   // qubit count register
   logic [QUBIT_W-1:0] qubit_count_ff;

   // request decode
   logic                 func_known;
   logic                 rotation;
   logic [CODE_W-1:0]    gate_code;
   logic [QUBIT_W-1:0]   qubits;
   logic [QUBIT_W-1:0]   stride_shift;
   logic [STRIDE_W-1:0]  stride;
   logic [QUBIT_W-1:0]   control_field;
   meta_type             entry_meta;
   logic                 entry_valid;

   // global pipeline advance: move on unless the output is held
   logic advance;

   // stage chain: index 0 is the reduced angle, index CORDIC_ITERATIONS the
   // last micro-rotation
   logic       chain_valid [CORDIC_ITERATIONS+1];
   meta_type   chain_meta  [CORDIC_ITERATIONS+1];
   vector_type chain_vec   [CORDIC_ITERATIONS+1];

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         qubit_count_ff <= QUBIT_COUNT_RESET;
      end else if (csr_chan.valid) begin
         qubit_count_ff <= csr_chan.data;
      end
   end

   always_comb begin
      func_known = 1'b1;
      rotation   = 1'b0;
      unique case (req_chan.func)
         FUNC_H:    gate_code = GATE_CODE_H;
         FUNC_S:    gate_code = GATE_CODE_S;
         FUNC_CNOT: gate_code = GATE_CODE_CNOT;
         FUNC_RX: begin
            gate_code = GATE_CODE_RX;
            rotation  = 1'b1;
         end
         FUNC_RY: begin
            gate_code = GATE_CODE_RY;
            rotation  = 1'b1;
         end
         FUNC_RZ: begin
            gate_code = GATE_CODE_RZ;
            rotation  = 1'b1;
         end
         default: begin
            gate_code  = GATE_CODE_NONE;
            func_known = 1'b0;
         end
      endcase
   end

   // stride 2^(qubits - target - 1); zero for S and for targets out of range
   assign qubits       = (qubit_count_ff > MAX_QUBITS) ? MAX_QUBITS : qubit_count_ff;
   assign stride_shift = qubits - req_chan.target - QUBIT_W'(1);

   always_comb begin
      if (req_chan.func != FUNC_S && req_chan.target < qubits) begin
         stride = STRIDE_W'(1) << stride_shift;
      end else begin
         stride = '0;
      end
   end

   // control index only for CNOT
   assign control_field = (req_chan.func == FUNC_CNOT) ? req_chan.control : '0;

   assign entry_meta.operand_word = {control_field, req_chan.target, stride};
   assign entry_meta.gate_code    = gate_code;
   assign entry_meta.rotation     = rotation;
   assign entry_meta.flip         = 1'b0;
   assign entry_valid             = req_chan.valid && func_known;

   qgde_angle_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (entry_valid),
      .in_meta   (entry_meta),
      .in_angle  (req_chan.angle),
      .out_valid (chain_valid[0]),
      .out_meta  (chain_meta[0]),
      .out_vec   (chain_vec[0])
   );

   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
      qgde_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_meta   (chain_meta[i]),
         .in_vec    (chain_vec[i]),
         .out_valid (chain_valid[i+1]),
         .out_meta  (chain_meta[i+1]),
         .out_vec   (chain_vec[i+1])
      );
   end

   qgde_finish u_finish (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (chain_valid[CORDIC_ITERATIONS]),
      .in_meta          (chain_meta[CORDIC_ITERATIONS]),
      .in_vec           (chain_vec[CORDIC_ITERATIONS]),
      .out_valid        (rsp_chan.valid),
      .out_operand_word (rsp_chan.operand_word),
      .out_cos_word     (rsp_chan.cos_word),
      .out_sin_word     (rsp_chan.sin_word),
      .out_gate_code    (rsp_chan.gate_code)
   );

endmodule

`default_nettype wire

// ----- design/qgde_checker.sv -----
// ---------------------------------------------------------------------------
// qgde_checker
// Port-level checks on the descriptor channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quantum_gate_descriptor_encoder_assert.svh"

module qgde_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [qgde_pkg::OPERAND_W-1:0]    rsp_operand_word,
   input logic signed [qgde_pkg::ROT_W-1:0] rsp_cos_word,
   input logic signed [qgde_pkg::ROT_W-1:0] rsp_sin_word,
   input logic [qgde_pkg::CODE_W-1:0]       rsp_gate_code
);
   import qgde_pkg::*;

   logic [OPERAND_W+2*ROT_W+CODE_W-1:0] rsp_payload;
   logic                                fixed_gate;

   assign rsp_payload = {rsp_operand_word, rsp_cos_word, rsp_sin_word, rsp_gate_code};
   assign fixed_gate  = rsp_gate_code == GATE_CODE_H || rsp_gate_code == GATE_CODE_S ||
                        rsp_gate_code == GATE_CODE_CNOT;

   `QGDE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "descriptor changed while stalled")
   `QGDE_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "descriptor offered straight after reset")
   `QGDE_ASSERT(a_fixed_no_rot, clock, reset, rsp_valid && fixed_gate |-> rsp_cos_word == 0 && rsp_sin_word == 0, "non-rotation gate carries rotation words")
   `QGDE_ASSERT(a_s_no_stride, clock, reset, rsp_valid && rsp_gate_code == GATE_CODE_S |-> rsp_operand_word[STRIDE_W-1:0] == 0, "S gate with non-zero stride")

endmodule

bind quantum_gate_descriptor_encoder qgde_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_operand_word (rsp_chan.operand_word),
   .rsp_cos_word     (rsp_chan.cos_word),
   .rsp_sin_word     (rsp_chan.sin_word),
   .rsp_gate_code    (rsp_chan.gate_code)
);

`default_nettype wire
